### hdl/cpr_pkg.sv
package cpr_pkg;

    localparam int unsigned FIELD_PAGE_W = 16;
    localparam int unsigned FIELD_FRAME_W = 4;
    localparam int unsigned CFG_W = 5;
    localparam int unsigned HIT_W = 32;

    typedef logic [FIELD_PAGE_W-1:0] page_field_t;
    typedef logic [CFG_W-1:0] cfg_field_t;

    typedef struct packed {
        logic                     hit;
        logic [FIELD_FRAME_W-1:0] frame_index;
        logic                     evicted_valid;
        page_field_t              evicted_page;
        logic [HIT_W-1:0]         hit_total;
    } result_t;

endpackage

### hdl/cpr_if.sv
interface cpr_req_if;
    logic                 valid;
    logic                 ready;
    cpr_pkg::page_field_t page_number;
    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

interface cpr_res_if;
    logic             valid;
    logic             ready;
    cpr_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpr_cfg_if;
    logic                valid;
    logic                ready;
    cpr_pkg::cfg_field_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/clock_page_replacement.sv
// channel | dir | payload
// req     | in  | page_number
// res     | out | hit, frame_index, evicted_valid, evicted_page, hit_total
// cfg     | in  | frames_in_use
// A request scans the lookup over the n frames in use (one page memory read
// per cycle, compared in the following cycle); a hit leaves the scan at the
// matching frame and loads the result register, which S_OUT then marks valid.
// A miss on a full table sweeps the hand over the frames, then writes back the
// new page and loads the result register.
// Reset clears valid and reference bits, hand, fill count and hit count at once.
// A result waits in the output register; the next request is taken once the
// result register is free.
module clock_page_replacement #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    cpr_req_if.sink req,
    cpr_res_if.source res,
    cpr_cfg_if.sink cfg
);
    localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
    localparam int unsigned HIT_W_L = cpr_pkg::HIT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [MAX_FRAMES-1:0] valid_reg, ref_reg;
    logic [CW-1:0] filled_reg;
    logic [IW-1:0] hand_reg;
    logic [HIT_W_L-1:0] hits_reg;
    cpr_pkg::cfg_field_t fiu_reg;
    logic [CW-1:0] n_reg;
    logic [IW-1:0] idx_reg, rd_idx_reg;
    logic rd_pend_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic ev_reg;
    cpr_pkg::result_t out_reg;
    logic out_valid_reg;

    logic [CW-1:0] n_calc;
    logic last_idx;
    logic [IW-1:0] hand_inc, idx_inc;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data = out_reg;

    // effective frame count from the register
    always_comb
    begin
        if (fiu_reg == '0)
            n_calc = CW'(1);
        else if (32'(fiu_reg) > MAX_FRAMES)
            n_calc = CW'(MAX_FRAMES);
        else
            n_calc = CW'(fiu_reg);
    end

    assign last_idx = (CW'(rd_idx_reg) + CW'(1)) >= n_reg;
    assign hand_inc = ((CW'(hand_reg) + CW'(1)) >= n_reg) ? '0 : hand_reg + IW'(1);
    assign idx_inc = idx_reg + IW'(1);

    // page memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            page_mem[hand_reg] <= page_reg;
        rd_data_reg <= page_mem[(state_reg == S_SWEEP || state_reg == S_WRITE) ?
                                hand_reg : idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.valid && req.ready) state_next = S_SCAN;
            S_SCAN:  state_next = S_SCAN;
            S_SWEEP: state_next = S_SWEEP;
            S_WRITE: state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control, lookup scan, sweep and write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            ref_reg <= '0;
            filled_reg <= '0;
            hand_reg <= '0;
            hits_reg <= '0;
            fiu_reg <= cpr_pkg::cfg_field_t'(16);
            n_reg <= '0;
            idx_reg <= '0;
            rd_idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            page_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            ev_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                fiu_reg <= cfg.data;
            if (res.valid && res.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        state_reg <= S_SCAN;
                        page_reg <= req.page_number[PAGE_BITS-1:0];
                        n_reg <= n_calc;
                        if (CW'(hand_reg) >= n_calc)
                            hand_reg <= '0;
                        idx_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        ev_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // issue read at idx, compare the previous one
                    rd_idx_reg <= idx_reg;
                    rd_pend_reg <= 1'b1;
                    idx_reg <= idx_inc;
                    if (rd_pend_reg && valid_reg[rd_idx_reg] && rd_data_reg == page_reg)
                    begin
                        ref_reg[rd_idx_reg] <= 1'b1;
                        if (hits_reg != '1)
                            hits_reg <= hits_reg + 1'b1;
                        out_reg.hit <= 1'b1;
                        out_reg.frame_index <= cpr_pkg::FIELD_FRAME_W'(rd_idx_reg);
                        out_reg.evicted_valid <= 1'b0;
                        out_reg.evicted_page <= '0;
                        out_reg.hit_total <= (hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
                        state_reg <= S_OUT;
                    end
                    else if (rd_pend_reg && last_idx)
                    begin
                        if (filled_reg < n_reg)
                        begin
                            if (valid_reg[hand_reg])
                                ev_reg <= 1'b1;
                            else
                                filled_reg <= filled_reg + CW'(1);
                            state_reg <= S_WRITE;
                        end
                        else
                            state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    // hand inspects bits; page read for eviction comes on write
                    if (!valid_reg[hand_reg])
                        state_reg <= S_WRITE;
                    else if (!ref_reg[hand_reg])
                    begin
                        ev_reg <= 1'b1;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        ref_reg[hand_reg] <= 1'b0;
                        hand_reg <= hand_inc;
                    end
                end
                S_WRITE:
                begin
                    // old page is read in this cycle; S_OUT takes it as the evicted page
                    valid_reg[hand_reg] <= 1'b1;
                    ref_reg[hand_reg] <= 1'b0;
                    out_reg.hit <= 1'b0;
                    out_reg.frame_index <= cpr_pkg::FIELD_FRAME_W'(hand_reg);
                    out_reg.evicted_valid <= ev_reg;
                    out_reg.hit_total <= hits_reg;
                    hand_reg <= hand_inc;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_reg.hit)
                        out_reg.evicted_page <= ev_reg ?
                            cpr_pkg::FIELD_PAGE_W'(rd_data_reg) : '0;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= state_next;
            endcase
        end
    end
endmodule

### sim/tb_clock_page_replacement.sv
module tb_clock_page_replacement;

    localparam int NFRAMES = 16;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;

    cpr_req_if req_ch();
    cpr_res_if res_ch();
    cpr_cfg_if cfg_ch();

    clock_page_replacement u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .res  (res_ch.source),
        .cfg  (cfg_ch.sink)
    );

    // predictor state
    cpr_pkg::page_field_t   pg_page [NFRAMES];
    logic                   pg_ref [NFRAMES];
    logic                   pg_valid [NFRAMES];
    int unsigned            pg_filled;
    int unsigned            pg_hand;
    logic [31:0]            pg_hits;
    cpr_pkg::cfg_field_t    pg_frames_cfg;

    cpr_pkg::page_field_t   page_queue[$];
    cpr_pkg::result_t       expected_results[$];
    cpr_pkg::cfg_field_t    phase_frames [6];
    int            error_count;
    int unsigned   sent_count;
    int unsigned   idle_cycles;
    bit            calm_phase;
    bit            stall_req;
    int unsigned   long_hold;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("error: %s got %0h want %0h", what, got, want);
            error_count++;
        end
    endtask

    // append one page to the pending requests
    task automatic queue_page(input cpr_pkg::page_field_t p);
        begin
            page_queue.insert(page_queue.size(), p);
        end
    endtask

    // compute the result of one page request and update the frame table
    function automatic cpr_pkg::result_t clock_lookup(input cpr_pkg::page_field_t pn);
        cpr_pkg::result_t r;
        int unsigned n;
        int unsigned victim;
        bit done;
        begin
            r = '0;
            n = (pg_frames_cfg == 0) ? 1 : (pg_frames_cfg > NFRAMES ? NFRAMES : pg_frames_cfg);
            if (pg_hand >= n) pg_hand = 0;
            for (int i = 0; i < n; i++) begin
                if (pg_valid[i] && pg_page[i] == pn) begin
                    pg_ref[i] = 1'b1;
                    if (pg_hits != 32'hFFFF_FFFF) pg_hits++;
                    r.hit = 1'b1;
                    r.frame_index = i[3:0];
                    r.hit_total = pg_hits;
                    return r;
                end
            end
            if (pg_filled < n) begin
                victim = pg_hand;
                if (pg_valid[victim]) begin
                    r.evicted_valid = 1'b1;
                    r.evicted_page = pg_page[victim];
                end
                else
                    pg_filled++;
            end
            else begin
                done = 0;
                victim = pg_hand;
                while (!done) begin
                    victim = pg_hand;
                    if (!pg_valid[victim]) done = 1;
                    else if (!pg_ref[victim]) begin
                        r.evicted_valid = 1'b1;
                        r.evicted_page = pg_page[victim];
                        done = 1;
                    end
                    else begin
                        pg_ref[victim] = 1'b0;
                        pg_hand = (pg_hand + 1) % n;
                    end
                end
            end
            pg_page[victim] = pn;
            pg_ref[victim] = 1'b0;
            pg_valid[victim] = 1'b1;
            pg_hand = (victim + 1) % n;
            r.frame_index = victim[3:0];
            r.hit_total = pg_hits;
            return r;
        end
    endfunction

    // request transfer seen at the last rising edge
    bit req_fire;
    always @(posedge clk) begin
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
    end

    // request driver
    int unsigned req_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (req_fire) begin
                void'(page_queue.pop_front());
            end
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (!calm_phase && !(req_ch.valid && !req_fire)
                     && $urandom_range(0, 9) == 0) begin
                req_gap <= $urandom_range(1, 15);
                req_ch.valid <= 1'b0;
            end
            else if (page_queue.size() > 0) begin
                req_ch.valid <= 1'b1;
                req_ch.page_number <= page_queue[0];
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result ready with bursts of back-pressure
    int unsigned res_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
                res_ch.ready <= 1'b0;
            end
            else if (stall_req) begin
                stall_req <= 1'b0;
                long_hold <= 300;
                res_ch.ready <= 1'b0;
            end
            else if (res_gap > 0) begin
                res_gap <= res_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                res_gap <= $urandom_range(1, 15);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on request transfer, check on result transfer
    cpr_pkg::result_t exp_r;
    bit               any_xfer;
    always @(posedge clk) begin
        if (rst_n) begin
            any_xfer = 1'b0;
            if (req_ch.valid && req_ch.ready) begin
                expected_results.insert(expected_results.size(),
                                        clock_lookup(req_ch.page_number));
                sent_count <= sent_count + 1;
                any_xfer = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                pg_frames_cfg = cfg_ch.data;
                any_xfer = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                any_xfer = 1'b1;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", 32'd0, 32'd0);
                else begin
                    exp_r = expected_results.pop_front();
                    if (res_ch.data.hit !== exp_r.hit)
                        report_mismatch("hit", 32'(res_ch.data.hit), 32'(exp_r.hit));
                    if (res_ch.data.frame_index !== exp_r.frame_index)
                        report_mismatch("frame_index", 32'(res_ch.data.frame_index),
                                        32'(exp_r.frame_index));
                    if (res_ch.data.evicted_valid !== exp_r.evicted_valid)
                        report_mismatch("evicted_valid", 32'(res_ch.data.evicted_valid),
                                        32'(exp_r.evicted_valid));
                    if (res_ch.data.evicted_page !== exp_r.evicted_page)
                        report_mismatch("evicted_page", 32'(res_ch.data.evicted_page),
                                        32'(exp_r.evicted_page));
                    if (res_ch.data.hit_total !== exp_r.hit_total)
                        report_mismatch("hit_total", res_ch.data.hit_total,
                                        exp_r.hit_total);
                end
            end
            if (any_xfer)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (idle_cycles > WATCH_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (page_queue.size() > 0 || req_ch.valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    task automatic write_frames(input cpr_pkg::cfg_field_t v);
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= v;
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            @(negedge clk);
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // a mostly well-formed mix: pages from a working set slightly above the frame count
    task automatic add_random(input int count, input int span);
        begin
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_page(cpr_pkg::page_field_t'($urandom));
                else
                    queue_page(cpr_pkg::page_field_t'(16'hA500 + $urandom_range(0, span)));
            end
        end
    endtask

    initial begin
        phase_frames = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12};
        clk = 0;
        rst_n = 0;
        req_ch.valid = 0;
        req_ch.page_number = '0;
        res_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        error_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        calm_phase = 0;
        stall_req = 0;
        long_hold = 0;
        req_gap = 0;
        res_gap = 0;
        pg_filled = 0;
        pg_hand = 0;
        pg_hits = '0;
        pg_frames_cfg = 5'd16;
        for (int i = 0; i < NFRAMES; i++) begin
            pg_page[i] = '0;
            pg_ref[i] = 0;
            pg_valid[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, fill, hit, duplicate pages and full sweeps at reset size
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'h5555);
        queue_page(16'hAAAA);
        for (int i = 0; i < 14; i++) queue_page(cpr_pkg::page_field_t'(16'h0100 + i));
        queue_page(16'hFFFF);
        queue_page(16'h0200);
        queue_page(16'h0201);
        stall_req = 1;
        wait_drained();

        // shrink to 4 frames: frames beyond count, hand beyond count
        write_frames(5'd4);
        for (int i = 0; i < 8; i++) queue_page(cpr_pkg::page_field_t'(16'h0300 + (i % 6)));
        wait_drained();
        // raise again: inserting onto valid frames
        write_frames(5'd10);
        add_random(12, 12);
        wait_drained();

        // random phases over several frame counts
        for (int p = 0; p < 6; p++) begin
            write_frames(phase_frames[p]);
            add_random(250, (phase_frames[p] == 0 ? 1 : phase_frames[p]) + 4);
            if (p == 2) stall_req = 1;
            if (p == 5) calm_phase = 1;
            wait_drained();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
